// File: src/mono_bitmap_to_vertical_pages_assert.svh
// Assertion macros for the checker file of the bitmap page converter.
// Depends on nothing; each macro expands to one clocked concurrent assertion.
`ifndef MONO_BITMAP_TO_VERTICAL_PAGES_ASSERT_SVH
`define MONO_BITMAP_TO_VERTICAL_PAGES_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBVP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mbvp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mbvp assertion failed");

`endif

// File: src/mbvp_pkg.sv
// Shared types and constants of the bitmap to vertical page converter.
// Depends on nothing; imported by the position control, the sequencer, the top level and the checker.
package mbvp_pkg;

	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 64;
	localparam int COLS_MAX    = MAX_WIDTH / 8;
	localparam int PAGES_MAX   = MAX_HEIGHT / 8;
	localparam int COL_W       = $clog2(COLS_MAX);
	localparam int ROW_W       = 3;
	localparam int PAGE_W      = 3;
	localparam int ROWS_STORED = 7;

	localparam int WIDTH_CFG_W  = 5;
	localparam int HEIGHT_CFG_W = 4;
	localparam int CFG_DATA_W   = 5;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_BYTES  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_PAGES = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LSB_FIRST    = 2'd2;

	localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic [7:0] page_byte;
		logic [6:0] column;
		logic [2:0] page;
		logic       last_of_run;
		logic       last_of_frame;
	} out_word_t;

	// Position of the word being accepted, after any frame restart.
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [PAGE_W-1:0] page;
		logic              frame_end;
	} pos_t;

endpackage

// File: src/mbvp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mbvp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/mbvp_pos_ctrl.sv
// Configuration registers and frame position counters of the page converter.
// Depends on mbvp_pkg.
module mbvp_pos_ctrl
	import mbvp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   accept,
	input  logic                   frame_start,
	output pos_t                   pos,
	output logic                   lsb_first
);

	logic [WIDTH_CFG_W-1:0]  width_q;
	logic [HEIGHT_CFG_W-1:0] height_q;
	logic                    lsb_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [PAGE_W-1:0]       page_q;

	logic [WIDTH_CFG_W-1:0]  eff_w;
	logic [HEIGHT_CFG_W-1:0] eff_h;
	logic [COL_W-1:0]        cur_col;
	logic [ROW_W-1:0]        cur_row;
	logic [PAGE_W-1:0]       cur_page;
	logic                    col_last;
	logic                    page_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_CFG_W'(COLS_MAX);
			height_q <= HEIGHT_CFG_W'(PAGES_MAX);
			lsb_q    <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIDTH_BYTES:  width_q  <= cfg_wdata[WIDTH_CFG_W-1:0];
				REG_HEIGHT_PAGES: height_q <= cfg_wdata[HEIGHT_CFG_W-1:0];
				REG_LSB_FIRST:    lsb_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Out-of-range sizes clamp to one and to the maximum frame.
	always_comb begin
		eff_w = width_q;
		if (width_q == '0) begin
			eff_w = WIDTH_CFG_W'(1);
		end else if (width_q > WIDTH_CFG_W'(COLS_MAX)) begin
			eff_w = WIDTH_CFG_W'(COLS_MAX);
		end
		eff_h = height_q;
		if (height_q == '0) begin
			eff_h = HEIGHT_CFG_W'(1);
		end else if (height_q > HEIGHT_CFG_W'(PAGES_MAX)) begin
			eff_h = HEIGHT_CFG_W'(PAGES_MAX);
		end
	end

	assign cur_col  = frame_start ? '0 : col_q;
	assign cur_row  = frame_start ? '0 : row_q;
	assign cur_page = frame_start ? '0 : page_q;

	// "At or beyond" so that a shrunk size mid-frame still wraps.
	assign col_last  = ({1'b0, cur_col} + (COL_W+1)'(1)) >= (COL_W+1)'(eff_w);
	assign page_last = ({1'b0, cur_page} + (PAGE_W+1)'(1)) >= eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			page_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				if (cur_row == LAST_ROW) begin
					row_q  <= '0;
					page_q <= page_last ? '0 : cur_page + PAGE_W'(1);
				end else begin
					row_q  <= cur_row + ROW_W'(1);
					page_q <= cur_page;
				end
			end else begin
				col_q  <= cur_col + COL_W'(1);
				row_q  <= cur_row;
				page_q <= cur_page;
			end
		end
	end

	assign pos.col       = cur_col;
	assign pos.row       = cur_row;
	assign pos.page      = cur_page;
	assign pos.frame_end = col_last && page_last;
	assign lsb_first     = lsb_q;

endmodule

// File: src/mbvp_emit.sv
// Page byte sequencer: one shared bit-gather unit run eight times per band column.
// Depends on mbvp_pkg.
module mbvp_emit
	import mbvp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  pos_t             pos,
	input  logic [7:0]       pixel_byte,
	input  logic [7:0]       row_rd [ROWS_STORED],
	input  logic             lsb_first,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic              state_q;
	logic [2:0]        k_q;
	logic [COL_W-1:0]  col_q;
	logic [PAGE_W-1:0] page_q;
	logic              frame_end_q;
	logic [7:0]        pix_q;
	logic              out_valid_q;
	out_word_t         out_q;

	logic [7:0] gather;
	logic [7:0] rb;
	logic       bit_v;
	logic       load;

	// Column k of the band: bit (7 - k) of each row byte, top row first.
	always_comb begin
		gather = '0;
		for (int r = 0; r < 8; r++) begin
			rb    = (r < ROWS_STORED) ? row_rd[r] : pix_q;
			bit_v = rb[~k_q];
			if (lsb_first) begin
				gather[r] = bit_v;
			end else begin
				gather[7-r] = bit_v;
			end
		end
	end

	assign load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (start) begin
						state_q <= ST_EMIT;
						k_q     <= '0;
					end
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						k_q         <= k_q + 3'd1;
						if (k_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			col_q       <= pos.col;
			page_q      <= pos.page;
			frame_end_q <= pos.frame_end;
			pix_q       <= pixel_byte;
		end
		if (load) begin
			out_q.page_byte     <= gather;
			out_q.column        <= {col_q, k_q};
			out_q.page          <= page_q;
			out_q.last_of_run   <= (k_q == 3'd7);
			out_q.last_of_frame <= (k_q == 3'd7) && frame_end_q;
		end
	end

	assign busy      = (state_q == ST_EMIT);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/mono_bitmap_to_vertical_pages.sv
// Row-major 1bpp bitmap to vertical page bytes, top level.
// The first page byte is registered from the row store and row 7 word once the
// sequencer is in its emit state. Row 0 to 6 words are taken while it is idle;
// after a row 7 word the input is held while the shared gather unit emits eight
// bytes, longer on an output stall. Reset clears counters and sequencer state,
// presets config; the band row store has no reset and is defined once written.
module mono_bitmap_to_vertical_pages
	import mbvp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_word_t              out_data
);

	logic       accept;
	logic       busy;
	logic       lsb_first;
	logic       start;
	pos_t       pos;
	logic [7:0] row_rd [ROWS_STORED];

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;
	assign start    = accept && (pos.row == LAST_ROW);

	mbvp_pos_ctrl u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.frame_start (in_data.frame_start),
		.pos         (pos),
		.lsb_first   (lsb_first)
	);

	// One row store per band row 0..6, addressed by byte-column.
	for (genvar r = 0; r < ROWS_STORED; r++) begin : g_row
		mbvp_ram #(
			.WIDTH (8),
			.DEPTH (COLS_MAX)
		) u_ram (
			.clk   (clk),
			.we    (accept && (pos.row == ROW_W'(r))),
			.waddr (pos.col),
			.wdata (in_data.pixel_byte),
			.re    (start),
			.raddr (pos.col),
			.rdata (row_rd[r])
		);
	end

	mbvp_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.pos        (pos),
		.pixel_byte (in_data.pixel_byte),
		.row_rd     (row_rd),
		.lsb_first  (lsb_first),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// File: src/mbvp_checker.sv
// Port-level checks of the page converter and the bind that attaches them.
// Depends on mbvp_pkg and mono_bitmap_to_vertical_pages_assert.svh.
`include "mono_bitmap_to_vertical_pages_assert.svh"

module mbvp_checker
	import mbvp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// A stalled word must not change.
	`MBVP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))

	// Every word that ends a frame also ends its run of eight.
	`MBVP_ASSERT_IMPLY(a_frame_end_run, clk, arst_n, out_valid && out_data.last_of_frame,
		out_data.last_of_run)

	// The run ends exactly on the rightmost column of a byte-column.
	`MBVP_ASSERT_IMPLY(a_run_col, clk, arst_n, out_valid,
		(out_data.column[2:0] == 3'd7) == out_data.last_of_run)

	// While a run is still being sent, no new word is taken.
	`MBVP_ASSERT_IMPLY(a_run_blocks_in, clk, arst_n,
		out_valid && out_ready && !out_data.last_of_run, !in_ready)

endmodule

bind mono_bitmap_to_vertical_pages mbvp_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
